FILE: rtl/core/ldfe_pkg.sv
package ldfe_pkg;

  localparam int FRAME_LEN = 14;
  localparam int NUM_CH    = 5;
  localparam int CNT_W     = $clog2(FRAME_LEN);

  typedef logic [7:0]         byte_t;
  typedef logic [7:0]         level_t;
  typedef logic [4:0]         current_t;
  typedef logic [2:0]         source_t;
  typedef logic [9:0]         level10_t;
  typedef logic [CNT_W-1:0]   count_t;
  typedef byte_t  [FRAME_LEN-1:0] frame_t;
  typedef level_t [NUM_CH-1:0]    levels_t;
  typedef byte_t  [NUM_CH-1:0]    lane_bytes_t;

  // Register indexes of the configuration port.
  typedef enum logic [2:0] {
    REG_RGB_CURRENT = 3'd0,
    REG_CW_CURRENT  = 3'd1,
    REG_SLOT0_SRC   = 3'd2,
    REG_SLOT1_SRC   = 3'd3,
    REG_SLOT2_SRC   = 3'd4,
    REG_SLOT3_SRC   = 3'd5,
    REG_SLOT4_SRC   = 3'd6
  } reg_index_t;

  localparam byte_t ADDR_STANDBY = 8'h81;
  localparam byte_t ADDR_DATA    = 8'hE1;
  localparam byte_t STANDBY_CMD  = 8'h03;
  localparam byte_t ZERO_BYTE    = 8'h00;
  localparam byte_t CW_PREFIX    = 8'hC0;
  localparam current_t RGB_IDLE_CODE = 5'd1;

  localparam current_t RGB_CURRENT_RST = 5'd14;
  localparam current_t CW_CURRENT_RST  = 5'd30;
  localparam source_t  SLOT0_SRC_RST   = 3'd2;
  localparam source_t  SLOT1_SRC_RST   = 3'd0;
  localparam source_t  SLOT2_SRC_RST   = 3'd1;
  localparam source_t  SLOT3_SRC_RST   = 3'd3;
  localparam source_t  SLOT4_SRC_RST   = 3'd4;

  // Frame assembled by the merge stage, with its valid flag.
  typedef struct packed {
    logic   valid;
    frame_t bytes;
  } frame_stage_t;

  // Keeps bits 7..1 and puts their XOR into bit 0.
  function automatic byte_t with_parity(byte_t b);
    return {b[7:1], ^b[7:1]};
  endfunction

endpackage

FILE: rtl/core/ldfe_if.sv
interface ldfe_in_if;
  logic                valid;
  logic                ready;
  ldfe_pkg::level_t    level_red;
  ldfe_pkg::level_t    level_green;
  ldfe_pkg::level_t    level_blue;
  ldfe_pkg::level_t    level_cold;
  ldfe_pkg::level_t    level_warm;

  modport source (output valid, level_red, level_green, level_blue, level_cold, level_warm,
                  input ready);
  modport sink   (input valid, level_red, level_green, level_blue, level_cold, level_warm,
                  output ready);
endinterface

interface ldfe_out_if;
  logic              valid;
  logic              ready;
  ldfe_pkg::byte_t   frame_byte;
  logic              is_address;
  logic              last;

  modport source (output valid, frame_byte, is_address, last, input ready);
  modport sink   (input valid, frame_byte, is_address, last, output ready);
endinterface

interface ldfe_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [4:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/core/ldfe_lane.sv
module ldfe_lane (
  input  ldfe_pkg::levels_t  levels,
  input  ldfe_pkg::source_t  source,
  output ldfe_pkg::byte_t    byte_hi,
  output ldfe_pkg::byte_t    byte_lo
);

  ldfe_pkg::level_t   v;
  logic [1:0]         frac;
  ldfe_pkg::level10_t l10;

  always_comb begin
    case (source)
      3'd0:    v = levels[0];
      3'd1:    v = levels[1];
      3'd2:    v = levels[2];
      3'd3:    v = levels[3];
      3'd4:    v = levels[4];
      default: v = '0;
    endcase
  end

  // v*1023/255 equals 4v plus floor(v/85), and v/85 never exceeds 3.
  always_comb begin
    if (v == 8'd255) begin
      frac = 2'd3;
    end else if (v >= 8'd170) begin
      frac = 2'd2;
    end else if (v >= 8'd85) begin
      frac = 2'd1;
    end else begin
      frac = 2'd0;
    end
  end

  assign l10     = {v, 2'b00} + {8'd0, frac};
  assign byte_hi = ldfe_pkg::with_parity({2'b00, l10[9:5], 1'b0});
  assign byte_lo = ldfe_pkg::with_parity({2'b00, l10[4:0], 1'b0});

endmodule

FILE: rtl/core/ldfe_merge.sv
module ldfe_merge (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  ldfe_pkg::levels_t       levels,
  input  ldfe_pkg::current_t      rgb_current,
  input  ldfe_pkg::current_t      cw_current,
  input  ldfe_pkg::lane_bytes_t   lane_hi,
  input  ldfe_pkg::lane_bytes_t   lane_lo,
  input  logic                    take,
  output ldfe_pkg::frame_stage_t  stage
);

  ldfe_pkg::frame_t   frame_next;
  ldfe_pkg::current_t rgb_code;
  ldfe_pkg::byte_t    cw_byte;
  logic               all_zero;
  logic               rgb_on;

  assign rgb_on   = (levels[0] != '0) || (levels[1] != '0) || (levels[2] != '0);
  assign all_zero = !rgb_on && (levels[3] == '0) && (levels[4] == '0);
  assign rgb_code = rgb_on ? rgb_current : ldfe_pkg::RGB_IDLE_CODE;
  assign cw_byte  = ldfe_pkg::with_parity(ldfe_pkg::CW_PREFIX | {2'b00, cw_current, 1'b0});

  always_comb begin
    frame_next[1] = ldfe_pkg::ZERO_BYTE;
    frame_next[3] = cw_byte;
    if (all_zero) begin
      frame_next[0] = ldfe_pkg::ADDR_STANDBY;
      frame_next[2] = ldfe_pkg::STANDBY_CMD;
      for (int i = 4; i < ldfe_pkg::FRAME_LEN; i++) begin
        frame_next[i] = ldfe_pkg::ZERO_BYTE;
      end
    end else begin
      frame_next[0] = ldfe_pkg::ADDR_DATA;
      frame_next[2] = ldfe_pkg::with_parity({2'b00, rgb_code, 1'b0});
      for (int i = 0; i < ldfe_pkg::NUM_CH; i++) begin
        frame_next[4 + 2 * i] = lane_hi[i];
        frame_next[5 + 2 * i] = lane_lo[i];
      end
    end
  end

  // The stage frees up in the same cycle the serializer takes its frame.
  assign in_ready = !stage.valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage.valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      stage.valid <= 1'b1;
    end else if (take) begin
      stage.valid <= 1'b0;
    end
    if (in_valid && in_ready) begin
      stage.bytes <= frame_next;
    end
  end

endmodule

FILE: rtl/core/ldfe_serializer.sv
module ldfe_serializer (
  input  logic                    clk,
  input  logic                    rst,
  input  ldfe_pkg::frame_stage_t  stage,
  output logic                    take,
  output logic                    out_valid,
  input  logic                    out_ready,
  output ldfe_pkg::byte_t         out_byte,
  output logic                    out_is_address,
  output logic                    out_last
);

  localparam ldfe_pkg::count_t LAST_IDX = ldfe_pkg::count_t'(ldfe_pkg::FRAME_LEN - 1);

  ldfe_pkg::frame_t shift;
  ldfe_pkg::count_t cnt;
  logic             busy;
  logic             xfer;

  assign xfer = busy && out_ready;
  assign take = stage.valid && (!busy || (xfer && cnt == LAST_IDX));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (take) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (xfer) begin
      if (cnt == LAST_IDX) begin
        busy <= 1'b0;
        cnt  <= '0;
      end else begin
        cnt <= cnt + 1'b1;
      end
    end
    if (take) begin
      shift <= stage.bytes;
    end else if (xfer) begin
      shift <= {ldfe_pkg::ZERO_BYTE, shift[ldfe_pkg::FRAME_LEN-1:1]};
    end
  end

  assign out_valid      = busy;
  assign out_byte       = shift[0];
  assign out_is_address = (cnt == '0);
  assign out_last       = (cnt == LAST_IDX);

endmodule

FILE: rtl/core/led_driver_frame_encoder.sv
// Five-channel LED driver frame encoder.
// The item channel carries five 8-bit levels (red, green, blue, cold, warm).
// Each accepted item yields one 14-byte command frame on the frame channel,
// one byte per transfer, first byte flagged is_address, final byte flagged last.
// The cfg channel writes the current codes and the slot routing; it is always
// ready and a write to an index beyond the register list is dropped.
// Five scaling lanes and the frame merge run in the cycle of the item
// transfer. The merged frame waits in a stage register until the serializer
// is free and is then loaded into the serializer shift register, which
// drives the first byte of the frame.
// Throughput: the serializer sends one byte per cycle while the receiver is
// ready. The next item is taken while the current frame is still going out,
// so the frame channel streams without gaps.
// When the receiver stalls, the current byte holds and at most one further
// frame waits in the stage register. Reset empties both stages and restores
// the register defaults.
module led_driver_frame_encoder (
  input  logic   clk,
  input  logic   rst,
  ldfe_in_if.sink    item,
  ldfe_out_if.source frame,
  ldfe_cfg_if.sink   cfg
);

  ldfe_pkg::current_t     rgb_current;
  ldfe_pkg::current_t     cw_current;
  ldfe_pkg::source_t      slot_source [ldfe_pkg::NUM_CH];
  ldfe_pkg::levels_t      levels;
  ldfe_pkg::lane_bytes_t  lane_hi;
  ldfe_pkg::lane_bytes_t  lane_lo;
  ldfe_pkg::frame_stage_t stage;
  logic                   take;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rgb_current    <= ldfe_pkg::RGB_CURRENT_RST;
      cw_current     <= ldfe_pkg::CW_CURRENT_RST;
      slot_source[0] <= ldfe_pkg::SLOT0_SRC_RST;
      slot_source[1] <= ldfe_pkg::SLOT1_SRC_RST;
      slot_source[2] <= ldfe_pkg::SLOT2_SRC_RST;
      slot_source[3] <= ldfe_pkg::SLOT3_SRC_RST;
      slot_source[4] <= ldfe_pkg::SLOT4_SRC_RST;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        ldfe_pkg::REG_RGB_CURRENT: rgb_current    <= cfg.data;
        ldfe_pkg::REG_CW_CURRENT:  cw_current     <= cfg.data;
        ldfe_pkg::REG_SLOT0_SRC:   slot_source[0] <= cfg.data[2:0];
        ldfe_pkg::REG_SLOT1_SRC:   slot_source[1] <= cfg.data[2:0];
        ldfe_pkg::REG_SLOT2_SRC:   slot_source[2] <= cfg.data[2:0];
        ldfe_pkg::REG_SLOT3_SRC:   slot_source[3] <= cfg.data[2:0];
        ldfe_pkg::REG_SLOT4_SRC:   slot_source[4] <= cfg.data[2:0];
        default: ;
      endcase
    end
  end

  assign levels[0] = item.level_red;
  assign levels[1] = item.level_green;
  assign levels[2] = item.level_blue;
  assign levels[3] = item.level_cold;
  assign levels[4] = item.level_warm;

  for (genvar i = 0; i < ldfe_pkg::NUM_CH; i++) begin : g_lane
    ldfe_lane u_lane (
      .levels  (levels),
      .source  (slot_source[i]),
      .byte_hi (lane_hi[i]),
      .byte_lo (lane_lo[i])
    );
  end

  ldfe_merge u_merge (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (item.valid),
    .in_ready    (item.ready),
    .levels      (levels),
    .rgb_current (rgb_current),
    .cw_current  (cw_current),
    .lane_hi     (lane_hi),
    .lane_lo     (lane_lo),
    .take        (take),
    .stage       (stage)
  );

  ldfe_serializer u_serializer (
    .clk            (clk),
    .rst            (rst),
    .stage          (stage),
    .take           (take),
    .out_valid      (frame.valid),
    .out_ready      (frame.ready),
    .out_byte       (frame.frame_byte),
    .out_is_address (frame.is_address),
    .out_last       (frame.last)
  );

endmodule

FILE: rtl/core/ldfe_checker.sv
module ldfe_checker (
  input logic            clk,
  input logic            rst,
  input logic            item_valid,
  input logic            item_ready,
  input logic            out_valid,
  input logic            out_ready,
  input ldfe_pkg::byte_t out_byte,
  input logic            out_is_address,
  input logic            out_last
);

  localparam ldfe_pkg::count_t LAST_IDX = ldfe_pkg::count_t'(ldfe_pkg::FRAME_LEN - 1);

  ldfe_pkg::count_t seen;
  logic             out_xfer;
  logic             item_xfer;

  assign out_xfer  = out_valid && out_ready;
  assign item_xfer = item_valid && item_ready;

  // Position of the next byte within its frame, counted from the port alone.
  always_ff @(posedge clk) begin
    if (rst) begin
      seen <= '0;
    end else if (out_xfer) begin
      seen <= (seen == LAST_IDX) ? '0 : seen + 1'b1;
    end
  end

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte))
    else $error("frame byte changed while stalled");

  a_frame_marks: assert property (@(posedge clk) disable iff (rst)
    out_xfer |-> (out_is_address == (seen == '0)) && (out_last == (seen == LAST_IDX)))
    else $error("address or last flag out of place in frame");

  a_address_byte: assert property (@(posedge clk) disable iff (rst)
    out_xfer && out_is_address |->
      (out_byte == ldfe_pkg::ADDR_STANDBY) || (out_byte == ldfe_pkg::ADDR_DATA))
    else $error("first frame byte is not an address");

  a_start_latency: assert property (@(posedge clk) disable iff (rst)
    item_xfer && !out_valid |-> ##2 out_valid)
    else $error("frame did not start after item transfer");

endmodule

bind led_driver_frame_encoder ldfe_checker u_ldfe_checker (
  .clk            (clk),
  .rst            (rst),
  .item_valid     (item.valid),
  .item_ready     (item.ready),
  .out_valid      (frame.valid),
  .out_ready      (frame.ready),
  .out_byte       (frame.frame_byte),
  .out_is_address (frame.is_address),
  .out_last       (frame.last)
);
